@@ hdl/mrs_pkg.sv @@
// Shared constants and control/status types for the MPU range region splitter.
package mrs_pkg;

  localparam int ADDR_W               = 32;
  localparam int REGION_W             = 4;
  localparam int REGION_COUNT_DEF     = 16;
  localparam int MIN_GRANULE_LOG2_DEF = 10;
  localparam int MAX_RESULTS          = 16;
  localparam int COUNT_W              = $clog2(MAX_RESULTS + 1);
  localparam int SIZE_CODE_MIN        = 4;
  localparam logic [REGION_W-1:0] FIRST_REGION_RST = REGION_W'(1);

  typedef struct packed {
    logic load;   // capture an accepted range word
    logic step;   // emit one region and advance
  } mrs_cmd_t;

  typedef struct packed {
    logic empty;      // offered range holds no region
    logic go;         // another region can be emitted
    logic last;       // the region being computed ends the range
    logic slot_free;  // output register can take a word this cycle
  } mrs_sts_t;

endpackage

@@ hdl/mrs_if.sv @@
// Valid/ready channel interfaces for range words and region words.
interface mrs_span_if import mrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              restart;
  logic [ADDR_W-1:0] start_address;
  logic [ADDR_W-1:0] end_address;
  logic [ADDR_W-1:0] access_bits;
  logic [ADDR_W-1:0] type_bits;

  modport source (output valid, restart, start_address, end_address, access_bits, type_bits,
                  input ready);
  modport sink (input valid, restart, start_address, end_address, access_bits, type_bits,
                output ready);
endinterface

interface mrs_region_if import mrs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REGION_W-1:0] region_number;
  logic [ADDR_W-1:0]   base_address;
  logic [ADDR_W-1:0]   attribute_word;
  logic                last;

  modport source (output valid, region_number, base_address, attribute_word, last,
                  input ready);
  modport sink (input valid, region_number, base_address, attribute_word, last,
                output ready);
endinterface

@@ hdl/mrs_ctrl.sv @@
// Sequencer for the region splitter: accepts a range, then steps regions out.
module mrs_ctrl import mrs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     span_valid,
  output logic     span_ready,
  input  mrs_sts_t sts,
  output mrs_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    span_ready = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        span_ready = 1'b1;
        if (span_valid) begin
          cmd.load = 1'b1;
          if (!sts.empty) state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (!sts.go) begin
          state_next = S_IDLE;
        end else if (sts.slot_free) begin
          cmd.step = 1'b1;
          if (sts.last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hdl/mrs_datapath.sv @@
// Region datapath: range registers, region size pick, counters, output register.
module mrs_datapath import mrs_pkg::*; #(
  parameter int REGION_COUNT     = REGION_COUNT_DEF,
  parameter int MIN_GRANULE_LOG2 = MIN_GRANULE_LOG2_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                first_region_we,
  input  logic [REGION_W-1:0] first_region_wdata,
  input  logic                restart,
  input  logic [ADDR_W-1:0]   start_address,
  input  logic [ADDR_W-1:0]   end_address,
  input  logic [ADDR_W-1:0]   access_bits,
  input  logic [ADDR_W-1:0]   type_bits,
  input  mrs_cmd_t            cmd,
  output mrs_sts_t            sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [REGION_W-1:0] region_number,
  output logic [ADDR_W-1:0]   base_address,
  output logic [ADDR_W-1:0]   attribute_word,
  output logic                last
);

  localparam int AW    = ADDR_W + 1;             // sizes reach 2^32
  localparam int LG_W  = $clog2(AW);
  localparam int CNT_W = $clog2(REGION_COUNT + 1);
  localparam logic [AW-1:0]    GRANULE  = AW'(1) << MIN_GRANULE_LOG2;
  localparam logic [CNT_W-1:0] SLOT_TOP = CNT_W'(REGION_COUNT - 1);

  logic [REGION_W-1:0] first_region;
  logic [CNT_W-1:0]    next_region;
  logic [COUNT_W-1:0]  emitted;
  logic [AW-1:0]       cur;
  logic [AW-1:0]       remain;
  logic [ADDR_W-1:0]   attr;

  logic [AW-1:0]       smear, hi_pow, low_bit, a_size, remain_after, cur_after;
  logic [LG_W-1:0]     lg;
  logic [4:0]          code;
  logic [CNT_W-1:0]    next_region_inc;
  logic [COUNT_W-1:0]  emitted_inc;

  // largest power of two not above remain: smear ones down, keep the top one
  always_comb begin
    smear = remain;
    for (int k = 0; k < LG_W; k++) begin
      smear = smear | (smear >> (1 << k));
    end
    hi_pow  = smear ^ (smear >> 1);
    low_bit = cur & (~cur + AW'(1));
    a_size  = (low_bit != '0 && low_bit < hi_pow) ? low_bit : hi_pow;
  end

  // a_size is one-hot: OR the set bit's index together
  always_comb begin
    lg = '0;
    for (int i = 0; i < AW; i++) begin
      if (a_size[i]) lg = lg | LG_W'(i);
    end
    code = (lg < LG_W'(5)) ? 5'(SIZE_CODE_MIN) : 5'(lg - LG_W'(1));
  end

  assign remain_after    = remain - a_size;
  assign cur_after       = cur + a_size;
  assign next_region_inc = next_region + CNT_W'(1);
  assign emitted_inc     = emitted + COUNT_W'(1);

  assign sts.empty     = (start_address >= end_address);
  assign sts.go        = (remain >= GRANULE) && (emitted < COUNT_W'(MAX_RESULTS)) &&
                         (next_region <= SLOT_TOP);
  assign sts.last      = (remain_after < GRANULE) || (emitted_inc == COUNT_W'(MAX_RESULTS)) ||
                         (next_region_inc > SLOT_TOP);
  assign sts.slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_region <= FIRST_REGION_RST;
      next_region  <= CNT_W'(1);
      out_valid    <= 1'b0;
    end else begin
      if (first_region_we) first_region <= first_region_wdata;
      if (cmd.load && restart) next_region <= CNT_W'(first_region);
      else if (cmd.step) next_region <= next_region_inc;
      if (cmd.step) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur     <= {1'b0, start_address};
      remain  <= {1'b0, end_address} - {1'b0, start_address} + AW'(1);
      attr    <= access_bits | type_bits;
      emitted <= '0;
    end else if (cmd.step) begin
      cur     <= cur_after;
      remain  <= remain_after;
      emitted <= emitted_inc;
    end
    if (cmd.step) begin
      region_number  <= next_region[REGION_W-1:0];
      base_address   <= cur[ADDR_W-1:0];
      attribute_word <= attr | {{(ADDR_W-6){1'b0}}, code, 1'b1};
      last           <= sts.last;
    end
  end

endmodule

@@ hdl/mpu_range_region_splitter_unit.sv @@
// Top level of the MPU range region splitter.
//
// A range word on span (restart, inclusive start/end address, access and
// type bits) is cut into naturally aligned power-of-two regions; one region
// word per region leaves on region, the final one flagged by last.
// Region numbers come from a running counter kept across words; restart
// reloads it from the first_region register (write first_region_we with
// first_region_wdata while idle). Emission stops once the counter passes
// REGION_COUNT-1, after 16 regions, or when under 2^MIN_GRANULE_LOG2 bytes
// remain. Ranges with start >= end produce nothing.
// Flow: a range word is taken only while the block is idle; each region then
// passes the size-select datapath (smear, lowest-set-bit, compare) and is
// stepped into the output register when it has room, so no new range word
// is taken until the current range is finished. span.ready is high only
// between ranges.
// A stalled region receiver freezes the stepping; the word sits in the
// output register and nothing is lost. Reset (rst, synchronous) empties the
// output, sets the counter and first_region to 1.
module mpu_range_region_splitter_unit import mrs_pkg::*; #(
  parameter int REGION_COUNT     = REGION_COUNT_DEF,
  parameter int MIN_GRANULE_LOG2 = MIN_GRANULE_LOG2_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                first_region_we,
  input  logic [REGION_W-1:0] first_region_wdata,
  mrs_span_if.sink            span,
  mrs_region_if.source        region
);

  mrs_cmd_t cmd;
  mrs_sts_t sts;

  mrs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .span_valid (span.valid),
    .span_ready (span.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mrs_datapath #(
    .REGION_COUNT     (REGION_COUNT),
    .MIN_GRANULE_LOG2 (MIN_GRANULE_LOG2)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .first_region_we    (first_region_we),
    .first_region_wdata (first_region_wdata),
    .restart            (span.restart),
    .start_address      (span.start_address),
    .end_address        (span.end_address),
    .access_bits        (span.access_bits),
    .type_bits          (span.type_bits),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (region.valid),
    .out_ready          (region.ready),
    .region_number      (region.region_number),
    .base_address       (region.base_address),
    .attribute_word     (region.attribute_word),
    .last               (region.last)
  );

`ifndef NO_ASSERTIONS
  // the block is busy in the cycle after a non-empty range is taken
  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    (span.valid && span.ready && !sts.empty) |=> !span.ready)
    else $error("span accepted again right after a non-empty range");

  // a region is stepped out only when it exists and the output can hold it
  a_step_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (sts.go && sts.slot_free))
    else $error("region stepped without room or without a region");

  // no region stepping while a new range is being taken
  a_no_step_idle: assert property (@(posedge clk) disable iff (rst)
    span.ready |-> !cmd.step)
    else $error("region step while idle");
`endif

endmodule

@@ verif/tb_mpu_range_region_splitter_unit.sv @@
// Testbench for the MPU range region splitter: directed table, then random ranges.
`timescale 1ns / 1ps

module tb_mpu_range_region_splitter_unit;
  import mrs_pkg::*;

  // Idle cycles allowed with no word moving on either channel.
  localparam int WATCHDOG_LIMIT = 2000;
  // Range words per random phase; five phases, one per first_region setting.
  localparam int RANGES_PER_PHASE = 78;
  localparam int PHASE_COUNT = 5;
  // Margin after the last expected region so that a range still in the block finishes.
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_IDLE = 19;
  localparam logic [32:0] GRANULE = 33'd1 << MIN_GRANULE_LOG2_DEF;

  typedef struct packed {
    logic              restart;
    logic [ADDR_W-1:0] start_address;
    logic [ADDR_W-1:0] end_address;
    logic [ADDR_W-1:0] access_bits;
    logic [ADDR_W-1:0] type_bits;
  } range_word_t;

  typedef struct packed {
    logic [REGION_W-1:0] region_number;
    logic [ADDR_W-1:0]   base_address;
    logic [ADDR_W-1:0]   attribute_word;
    logic                last;
  } region_word_t;

  // One directed row. When fixed_result is set the expected output is typed in
  // the table (has_region says whether one region word is due); otherwise the
  // splitter model supplies it.
  typedef struct {
    range_word_t  range;
    bit           fixed_result;
    bit           has_region;
    region_word_t region;
  } directed_row_t;

  localparam region_word_t NO_REGION = '0;
  localparam int DIRECTED_ROWS = 17;

  // Counter state after reset: next slot 1, first_region 1.
  directed_row_t directed_table [DIRECTED_ROWS] = '{
    // whole 4 GiB space: one region, size code 31
    '{'{1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0}, 1'b1, 1'b1,
      '{4'd1, 32'h0000_0000, 32'h0000_003F, 1'b1}},
    // start equal to end: nothing
    '{'{1'b0, 32'h0000_1000, 32'h0000_1000, 32'h0, 32'h0}, 1'b1, 1'b0, NO_REGION},
    // start above end: nothing
    '{'{1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 32'h0}, 1'b1, 1'b0, NO_REGION},
    // 1023 bytes: under the granule, nothing
    '{'{1'b0, 32'h0000_2000, 32'h0000_23FE, 32'h0, 32'h0}, 1'b1, 1'b0, NO_REGION},
    // exactly 1 KiB, all access bits set
    '{'{1'b0, 32'h0000_0400, 32'h0000_07FF, 32'hFFFF_FFFF, 32'h0}, 1'b1, 1'b1,
      '{4'd2, 32'h0000_0400, 32'hFFFF_FFFF, 1'b1}},
    // top 1 KiB of the space, all type bits set
    '{'{1'b0, 32'hFFFF_FC00, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF}, 1'b1, 1'b1,
      '{4'd3, 32'hFFFF_FC00, 32'hFFFF_FFFF, 1'b1}},
    // odd start halves down to a 1-byte region (code 4), rest under granule
    '{'{1'b0, 32'h0000_0001, 32'h0000_0400, 32'h0, 32'h0}, 1'b1, 1'b1,
      '{4'd4, 32'h0000_0001, 32'h0000_0009, 1'b1}},
    // restart reloads the counter from the reset value of first_region
    '{'{1'b1, 32'h0000_0000, 32'h0000_FFFF, 32'h5, 32'h30}, 1'b0, 1'b0, NO_REGION},
    // staircase of growing regions
    '{'{1'b0, 32'h0000_0400, 32'h0007_FFFF, 32'h0, 32'h0}, 1'b0, 1'b0, NO_REGION},
    // runs the counter past slot 15 partway through
    '{'{1'b0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0, 32'h0}, 1'b0, 1'b0, NO_REGION},
    // counter used up, no restart: nothing
    '{'{1'b0, 32'h0000_0000, 32'h000F_FFFF, 32'h0, 32'h0}, 1'b1, 1'b0, NO_REGION},
    // unaligned start over the whole space: 15 regions, then counter runs out
    '{'{1'b1, 32'h0000_0001, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h0F0F_0000}, 1'b0, 1'b0,
      NO_REGION},
    // one 1 KiB region, remainder under granule dropped
    '{'{1'b1, 32'h0001_0000, 32'h0001_07FE, 32'h0, 32'h0}, 1'b0, 1'b0, NO_REGION},
    // upper half of the space
    '{'{1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'hF0}, 1'b0, 1'b0, NO_REGION},
    // two-byte range: under granule, restart still happens
    '{'{1'b1, 32'h0000_0000, 32'h0000_0001, 32'h0, 32'h0}, 1'b1, 1'b0, NO_REGION},
    // 1023 bytes at the very top
    '{'{1'b1, 32'hFFFF_FC00, 32'hFFFF_FFFE, 32'h0, 32'h0}, 1'b1, 1'b0, NO_REGION},
    '{'{1'b0, 32'h0000_0C00, 32'h0000_3FFF, 32'h8000_0000, 32'h1}, 1'b0, 1'b0, NO_REGION}
  };

  logic clk;
  logic rst;
  logic first_region_we;
  logic [REGION_W-1:0] first_region_wdata;

  mrs_span_if   span_ch ();
  mrs_region_if region_ch ();

  mpu_range_region_splitter_unit dut (
    .clk                (clk),
    .rst                (rst),
    .first_region_we    (first_region_we),
    .first_region_wdata (first_region_wdata),
    .span               (span_ch),
    .region             (region_ch)
  );

  // Model state: shadow of first_region and the running slot counter.
  logic [REGION_W-1:0] first_region_shadow = FIRST_REGION_RST;
  logic [REGION_W:0]   slot_counter = 5'd1;

  region_word_t expected_regions[$];
  int fail_count = 0;
  int quiet_cycles = 0;
  int region_stall = 0;
  bit no_idle = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Cut one accepted range into regions and queue the region words it yields.
  function automatic void split_range(input range_word_t w, ref region_word_t q[$]);
    logic [32:0] remain;
    logic [32:0] cur;
    logic [32:0] chunk;
    logic [ADDR_W-1:0] attr;
    int lg;
    int code;
    int emitted;
    if (w.restart) slot_counter = {1'b0, first_region_shadow};
    if (w.start_address >= w.end_address) return;
    remain  = {1'b0, w.end_address} - {1'b0, w.start_address} + 33'd1;
    cur     = {1'b0, w.start_address};
    attr    = w.access_bits | w.type_bits;
    emitted = 0;
    while (remain >= GRANULE && emitted < MAX_RESULTS &&
           slot_counter <= REGION_COUNT_DEF - 1) begin
      // largest power of two not above the remainder: its top set bit
      chunk = 33'd0;
      for (int b = 0; b <= 32; b++) begin
        if (remain[b]) chunk = 33'd1 << b;
      end
      // shrink until the current address is naturally aligned
      while ((cur & (chunk - 33'd1)) != 33'd0) chunk = chunk >> 1;
      lg = 0;
      for (int b = 0; b <= 32; b++) begin
        if (chunk[b]) lg = b;
      end
      code = (chunk < 33'd32) ? SIZE_CODE_MIN : lg - 1;
      q.push_back('{slot_counter[REGION_W-1:0], cur[ADDR_W-1:0],
                    attr | (32'(code) << 1) | 32'd1, 1'b0});
      cur = cur + chunk;
      remain = remain - chunk;
      slot_counter = slot_counter + 5'd1;
      emitted++;
    end
    if (emitted > 0) q[q.size()-1].last = 1'b1;
  endfunction

  // Random range word. Most are aligned ranges of random length; the rest are
  // fully random, inverted, too short, or close to the whole address space.
  function automatic range_word_t random_range();
    range_word_t w;
    int kind;
    int align;
    int span_log;
    logic [63:0] len;
    logic [63:0] stop;
    kind = $urandom_range(0, 99);
    w.restart = ($urandom_range(0, 9) < 4);
    w.access_bits = $urandom_range(0, 1) ? ($urandom & 32'hFFFF_0000) : $urandom;
    w.type_bits = $urandom_range(0, 1) ? ($urandom & 32'h0000_FF00) : $urandom;
    w.start_address = $urandom;
    w.end_address = $urandom;
    if (kind < 60) begin
      align = $urandom_range(0, 24);
      span_log = $urandom_range(10, 31);
      w.start_address = $urandom & (32'hFFFF_FFFF << align);
      len = (64'($urandom) & ((64'd1 << span_log) - 64'd1)) + 64'd1024;
      stop = {32'd0, w.start_address} + len - 64'd1;
      w.end_address = (stop > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : stop[31:0];
    end else if (kind < 85 && kind >= 75) begin
      w.end_address = w.start_address - 32'($urandom_range(0, 255));
    end else if (kind < 93 && kind >= 85) begin
      w.end_address = w.start_address + 32'($urandom_range(1, 1022));
    end else if (kind >= 93) begin
      w.start_address = $urandom_range(0, 1) ? 32'h0 : ($urandom & 32'h3FF);
      w.end_address = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ~($urandom & 32'h3FF);
    end
    return w;
  endfunction

  // Offer one range word after a random gap and queue its expected regions
  // at the edge where it is taken.
  task automatic send_range(input range_word_t w, input bit fixed_result,
                            input bit has_region, input region_word_t fixed);
    region_word_t scratch[$];
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    repeat (gap) begin
      @(negedge clk);
      span_ch.valid = 1'b0;
    end
    @(negedge clk);
    span_ch.valid         = 1'b1;
    span_ch.restart       = w.restart;
    span_ch.start_address = w.start_address;
    span_ch.end_address   = w.end_address;
    span_ch.access_bits   = w.access_bits;
    span_ch.type_bits     = w.type_bits;
    do @(posedge clk); while (!span_ch.ready);
    if (fixed_result) begin
      // model still runs so the counter tracks, but the table has the answer
      split_range(w, scratch);
      if (has_region) expected_regions.push_back(fixed);
    end else begin
      split_range(w, expected_regions);
    end
  endtask

  // Wait for every queued region, then let a range with no output finish.
  task automatic drain();
    @(negedge clk);
    span_ch.valid = 1'b0;
    while (expected_regions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_first_region(input logic [REGION_W-1:0] value);
    @(negedge clk);
    first_region_we    = 1'b1;
    first_region_wdata = value;
    @(negedge clk);
    first_region_we    = 1'b0;
    first_region_shadow = value;
  endtask

  task automatic check_region(input region_word_t got);
    region_word_t want;
    if (expected_regions.size() == 0) begin
      $display("%0t: region word with none expected: num %0d base %h attr %h last %0b",
               $time, got.region_number, got.base_address, got.attribute_word, got.last);
      fail_count++;
      return;
    end
    want = expected_regions.pop_front();
    if (got.region_number !== want.region_number) begin
      $display("%0t: region_number expected %0d got %0d",
               $time, want.region_number, got.region_number);
      fail_count++;
    end
    if (got.base_address !== want.base_address) begin
      $display("%0t: base_address expected %h got %h",
               $time, want.base_address, got.base_address);
      fail_count++;
    end
    if (got.attribute_word !== want.attribute_word) begin
      $display("%0t: attribute_word expected %h got %h",
               $time, want.attribute_word, got.attribute_word);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
      fail_count++;
    end
  endtask

  // Region receiver: check each word taken, then draw the stall before the next.
  always @(posedge clk) begin
    if (!rst && region_ch.valid && region_ch.ready) begin
      check_region('{region_ch.region_number, region_ch.base_address,
                     region_ch.attribute_word, region_ch.last});
      region_stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    end else if (region_stall != 0) begin
      region_stall--;
    end
  end

  always @(negedge clk) begin
    region_ch.ready = (region_stall == 0);
  end

  // Watchdog: any word moving on either channel counts as progress.
  always @(posedge clk) begin
    if ((span_ch.valid && span_ch.ready) || (region_ch.valid && region_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [REGION_W-1:0] setting;
    rst                   = 1'b1;
    first_region_we       = 1'b0;
    first_region_wdata    = '0;
    span_ch.valid         = 1'b0;
    span_ch.restart       = 1'b0;
    span_ch.start_address = '0;
    span_ch.end_address   = '0;
    span_ch.access_bits   = '0;
    span_ch.type_bits     = '0;
    region_ch.ready       = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows run with first_region at its reset value.
    for (int row = 0; row < DIRECTED_ROWS; row++) begin
      send_range(directed_table[row].range, directed_table[row].fixed_result,
                 directed_table[row].has_region, directed_table[row].region);
    end
    drain();

    // Random phases: first_region at 0, 15, mid-range, 1, anything. Each phase
    // boundary holds the sender until every region has come back. The third
    // phase runs both sides with no idling at all.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: setting = 4'd0;
        1: setting = 4'd15;
        2: setting = 4'($urandom_range(2, 14));
        3: setting = 4'd1;
        default: setting = 4'($urandom_range(0, 15));
      endcase
      write_first_region(setting);
      no_idle = (phase == 2);
      for (int n = 0; n < RANGES_PER_PHASE; n++) begin
        send_range(random_range(), 1'b0, 1'b0, NO_REGION);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
